// ===== src/nsd_pkg.sv =====
// Package for the NMEA sentence deframer: phase and drop-reason types,
// character constants and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package nsd_pkg;

   localparam logic [7:0] CH_START = 8'h24;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [7:0] MAX_LEN_RESET = 8'd88;

   // Smallest frame that can close good: '$', '*', two digits, CR, LF.
   localparam logic [7:0] MIN_GOOD_LEN = 8'd6;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_LEN_ADDR = 3'd0;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_BODY = 3'd1,
      PH_HI   = 3'd2,
      PH_LO   = 3'd3,
      PH_CR   = 3'd4,
      PH_LF   = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      DROP_NONE     = 3'd0,
      DROP_OVERFLOW = 3'd1,
      DROP_CHECKSUM = 3'd2,
      DROP_NO_CR    = 3'd3,
      DROP_NO_LF    = 3'd4
   } drop_reason_type;

   // Returns {digit_ok, nibble}; the nibble is zero when the digit is bad.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] diff;
      logic [4:0] res;
      res  = 5'd0;
      diff = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         diff = c - 8'h30;
         res  = {1'b1, diff[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         diff = c - 8'h37;
         res  = {1'b1, diff[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         diff = c - 8'h57;
         res  = {1'b1, diff[3:0]};
      end
      return res;
   endfunction

endpackage

// ===== src/nsd_if.sv =====
// Stream channel interfaces for the deframer: received bytes in, per-byte
// results out. Depends on nothing.
`timescale 1ns / 1ps

interface nsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       byte_in_frame;
   logic       frame_start;
   logic       frame_good;
   logic [2:0] drop_reason;
   logic [7:0] frame_length;
   logic [7:0] computed_checksum;

   modport source (output valid, output byte_out, output byte_in_frame,
                   output frame_start, output frame_good, output drop_reason,
                   output frame_length, output computed_checksum, input ready);
   modport sink   (input valid, input byte_out, input byte_in_frame,
                   input frame_start, input frame_good, input drop_reason,
                   input frame_length, input computed_checksum, output ready);
endinterface

// ===== src/nsd_csr.sv =====
// APB-style register block holding the frame length limit.
// Depends on nsd_pkg.
`timescale 1ns / 1ps

module nsd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [nsd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output logic [7:0]                      max_frame_len
);

   logic [7:0] max_len_ff;
   logic [7:0] max_len_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite &&
                  (csr_paddr == nsd_pkg::CSR_MAX_LEN_ADDR);

   always_comb begin
      max_len_in = max_len_ff;
      if (wr_en) begin
         max_len_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= nsd_pkg::MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr == nsd_pkg::CSR_MAX_LEN_ADDR) begin
         csr_prdata = {24'd0, max_len_ff};
      end
   end

   assign max_frame_len = max_len_ff;

endmodule

// ===== src/nsd_core.sv =====
// Deframer datapath: input byte register, phase machine with checksum and
// length tracking, and the result register. Depends on nsd_pkg and nsd_if.
`timescale 1ns / 1ps

module nsd_core (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] max_frame_len,
   nsd_req_if.sink    req,
   nsd_rsp_if.source  rsp
);

   // Input stage.
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] in_byte_in;
   logic       advance;

   // Frame state.
   nsd_pkg::phase_type phase_ff;
   nsd_pkg::phase_type phase_in;
   nsd_pkg::phase_type phase_eff;
   logic [7:0] xor_ff;
   logic [7:0] xor_in;
   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic [3:0] nibble_ff;
   logic [3:0] nibble_in;
   logic       high_bad_ff;
   logic       high_bad_in;

   logic       overflow;
   logic [4:0] digit;
   logic       check_fail;

   // Per-byte result.
   logic                     in_frame;
   logic                     start;
   logic                     good;
   logic                     show;
   nsd_pkg::drop_reason_type reason;

   // Result register.
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_in_frame_ff;
   logic       out_start_ff;
   logic       out_good_ff;
   logic [2:0] out_reason_ff;
   logic [7:0] out_length_ff;
   logic [7:0] out_chk_ff;

   assign advance = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // An open frame that has reached the limit is dropped first; the byte is
   // then treated as if the deframer were idle.
   assign overflow  = (phase_ff != nsd_pkg::PH_IDLE) && (count_ff >= max_frame_len);
   assign phase_eff = overflow ? nsd_pkg::PH_IDLE : phase_ff;
   assign digit     = nsd_pkg::hex_decode(in_byte_ff);
   assign check_fail = !digit[4] || high_bad_ff || ({nibble_ff, digit[3:0]} != xor_ff);

   // Next state.
   always_comb begin
      phase_in    = phase_eff;
      xor_in      = xor_ff;
      count_in    = count_ff;
      nibble_in   = nibble_ff;
      high_bad_in = high_bad_ff;
      unique case (phase_eff)
         nsd_pkg::PH_IDLE: begin
            if (in_byte_ff == nsd_pkg::CH_START) begin
               count_in    = 8'd1;
               xor_in      = 8'd0;
               nibble_in   = 4'd0;
               high_bad_in = 1'b0;
               phase_in    = nsd_pkg::PH_BODY;
            end
         end
         nsd_pkg::PH_BODY: begin
            count_in = count_ff + 8'd1;
            if (in_byte_ff == nsd_pkg::CH_STAR) begin
               phase_in = nsd_pkg::PH_HI;
            end else begin
               xor_in = xor_ff ^ in_byte_ff;
            end
         end
         nsd_pkg::PH_HI: begin
            count_in    = count_ff + 8'd1;
            high_bad_in = !digit[4];
            nibble_in   = digit[3:0];
            phase_in    = nsd_pkg::PH_LO;
         end
         nsd_pkg::PH_LO: begin
            count_in = count_ff + 8'd1;
            phase_in = check_fail ? nsd_pkg::PH_IDLE : nsd_pkg::PH_CR;
         end
         nsd_pkg::PH_CR: begin
            if (in_byte_ff == nsd_pkg::CH_CR) begin
               count_in = count_ff + 8'd1;
               phase_in = nsd_pkg::PH_LF;
            end else begin
               phase_in = nsd_pkg::PH_IDLE;
            end
         end
         nsd_pkg::PH_LF: begin
            if (in_byte_ff == nsd_pkg::CH_LF) begin
               count_in = count_ff + 8'd1;
            end
            phase_in = nsd_pkg::PH_IDLE;
         end
         default: begin
            phase_in = nsd_pkg::PH_IDLE;
         end
      endcase
   end

   // Per-byte outputs.
   always_comb begin
      in_frame = 1'b0;
      start    = 1'b0;
      good     = 1'b0;
      reason   = overflow ? nsd_pkg::DROP_OVERFLOW : nsd_pkg::DROP_NONE;
      unique case (phase_eff) inside
         nsd_pkg::PH_IDLE: begin
            if (in_byte_ff == nsd_pkg::CH_START) begin
               in_frame = 1'b1;
               start    = 1'b1;
            end
         end
         nsd_pkg::PH_BODY, nsd_pkg::PH_HI: begin
            in_frame = 1'b1;
         end
         nsd_pkg::PH_LO: begin
            in_frame = 1'b1;
            if (check_fail) begin
               reason = nsd_pkg::DROP_CHECKSUM;
            end
         end
         nsd_pkg::PH_CR: begin
            if (in_byte_ff == nsd_pkg::CH_CR) begin
               in_frame = 1'b1;
            end else begin
               reason = nsd_pkg::DROP_NO_CR;
            end
         end
         nsd_pkg::PH_LF: begin
            if (in_byte_ff == nsd_pkg::CH_LF) begin
               in_frame = 1'b1;
               good     = 1'b1;
            end else begin
               reason = nsd_pkg::DROP_NO_LF;
            end
         end
         default: begin
            in_frame = 1'b0;
         end
      endcase
      // Lengths are shown for stored bytes and for any byte that drops a frame.
      show = in_frame || (reason != nsd_pkg::DROP_NONE);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= nsd_pkg::PH_IDLE;
         xor_ff       <= 8'd0;
         count_ff     <= 8'd0;
         nibble_ff    <= 4'd0;
         high_bad_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff    <= phase_in;
            xor_ff      <= xor_in;
            count_ff    <= count_in;
            nibble_ff   <= nibble_in;
            high_bad_ff <= high_bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (advance) begin
         out_byte_ff     <= in_byte_ff;
         out_in_frame_ff <= in_frame;
         out_start_ff    <= start;
         out_good_ff     <= good;
         out_reason_ff   <= reason;
         out_length_ff   <= show ? count_in : 8'd0;
         out_chk_ff      <= show ? xor_in : 8'd0;
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.byte_out          = out_byte_ff;
   assign rsp.byte_in_frame     = out_in_frame_ff;
   assign rsp.frame_start       = out_start_ff;
   assign rsp.frame_good        = out_good_ff;
   assign rsp.drop_reason       = out_reason_ff;
   assign rsp.frame_length      = out_length_ff;
   assign rsp.computed_checksum = out_chk_ff;

   // A held input byte is not lost while the result side stalls.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte lost while stalled");

   // An opening dollar always leaves the machine collecting the body.
   a_start_body: assert property (@(posedge clock) disable iff (reset)
      advance && start |=> phase_ff == nsd_pkg::PH_BODY)
      else $error("frame start did not enter body phase");

   // A good frame is never also a drop, and holds at least the minimal sentence.
   a_good_len: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.frame_good |->
         rsp.drop_reason == nsd_pkg::DROP_NONE &&
         rsp.frame_length >= nsd_pkg::MIN_GOOD_LEN)
      else $error("good frame with drop or short length");

   // A frame start is a stored dollar with length one.
   a_start_byte: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.frame_start |->
         rsp.byte_out == nsd_pkg::CH_START && rsp.byte_in_frame &&
         rsp.frame_length == 8'd1)
      else $error("frame start result inconsistent");

endmodule

// ===== src/nmea_sentence_deframer_top.sv =====
// An accepted byte passes the input register, then the result register, before its
// result beat is offered. Throughput: one byte per cycle while the receiver takes
// results, set by the combinational phase update between the two registers.
// Reset (synchronous, active high) empties both stages, returns the phase machine
// to idle with zero checksum and count, and sets max_frame_len to 88.
// Top level of the deframer; depends on nsd_pkg, nsd_if, nsd_csr and nsd_core.
`timescale 1ns / 1ps

module nmea_sentence_deframer_top (
   input  logic                            clock,
   input  logic                            reset,
   nsd_req_if.sink                         req_ch,
   nsd_rsp_if.source                       rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [nsd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [7:0] max_frame_len;

   nsd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .max_frame_len (max_frame_len)
   );

   nsd_core u_core (
      .clock         (clock),
      .reset         (reset),
      .max_frame_len (max_frame_len),
      .req           (req_ch),
      .rsp           (rsp_ch)
   );

endmodule

// ===== dv/nsd_deframe_checker.sv =====
// Checker for the NMEA sentence deframer: tracks the frame state byte by byte,
// queues the expected result beats and compares them with the result channel.
// Depends on nsd_pkg and nsd_if.
`timescale 1ns / 1ps

module nsd_deframe_checker (
   input  logic                           clock,
   input  logic                           reset,
   nsd_req_if                             req_mon,
   nsd_rsp_if                             rsp_mon,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [nsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output int                             fail_count,
   output int                             pending_count
);

   typedef struct packed {
      logic [7:0]               byte_out;
      logic                     in_frame;
      logic                     start;
      logic                     good;
      nsd_pkg::drop_reason_type reason;
      logic [7:0]               length;
      logic [7:0]               xsum;
   } frame_beat_type;

   frame_beat_type expected_beats[$];
   int             mismatches = 0;
   int             outstanding = 0;

   // Shadow of the deframer state and of its length limit.
   nsd_pkg::phase_type cur_phase;
   logic [7:0]         run_xor;
   logic [7:0]         frame_count;
   logic [3:0]         hi_nib;
   logic               hi_bad;
   logic [7:0]         len_limit;

   assign fail_count    = mismatches;
   assign pending_count = outstanding;

   function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] nib);
      nib = 4'd0;
      if (c >= "0" && c <= "9") begin
         nib = c[3:0];
         return 1'b1;
      end
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
         nib = c[3:0] + 4'd9;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic frame_beat_type deframe_byte(input logic [7:0] b);
      frame_beat_type r;
      logic           show;
      logic           ok;
      logic [3:0]     nib;
      r          = '0;
      r.byte_out = b;
      show       = 1'b0;
      // An open frame at its limit is dropped, and the byte is then seen as in idle.
      if (cur_phase != nsd_pkg::PH_IDLE && frame_count >= len_limit) begin
         r.reason  = nsd_pkg::DROP_OVERFLOW;
         show      = 1'b1;
         cur_phase = nsd_pkg::PH_IDLE;
      end
      case (cur_phase)
         nsd_pkg::PH_IDLE: begin
            if (b == nsd_pkg::CH_START) begin
               frame_count = 8'd1;
               run_xor     = 8'd0;
               hi_nib      = 4'd0;
               hi_bad      = 1'b0;
               cur_phase   = nsd_pkg::PH_BODY;
               r.in_frame  = 1'b1;
               r.start     = 1'b1;
            end
         end
         nsd_pkg::PH_BODY: begin
            frame_count = frame_count + 8'd1;
            r.in_frame  = 1'b1;
            if (b == nsd_pkg::CH_STAR) cur_phase = nsd_pkg::PH_HI;
            else run_xor = run_xor ^ b;
         end
         nsd_pkg::PH_HI: begin
            frame_count = frame_count + 8'd1;
            r.in_frame  = 1'b1;
            hi_bad      = !hex_nibble(b, nib);
            hi_nib      = nib;
            cur_phase   = nsd_pkg::PH_LO;
         end
         nsd_pkg::PH_LO: begin
            frame_count = frame_count + 8'd1;
            r.in_frame  = 1'b1;
            ok          = hex_nibble(b, nib);
            if (!ok || hi_bad || {hi_nib, nib} != run_xor) begin
               r.reason  = nsd_pkg::DROP_CHECKSUM;
               cur_phase = nsd_pkg::PH_IDLE;
            end else begin
               cur_phase = nsd_pkg::PH_CR;
            end
         end
         nsd_pkg::PH_CR: begin
            if (b == nsd_pkg::CH_CR) begin
               frame_count = frame_count + 8'd1;
               r.in_frame  = 1'b1;
               cur_phase   = nsd_pkg::PH_LF;
            end else begin
               r.reason  = nsd_pkg::DROP_NO_CR;
               show      = 1'b1;
               cur_phase = nsd_pkg::PH_IDLE;
            end
         end
         nsd_pkg::PH_LF: begin
            if (b == nsd_pkg::CH_LF) begin
               frame_count = frame_count + 8'd1;
               r.in_frame  = 1'b1;
               r.good      = 1'b1;
            end else begin
               r.reason = nsd_pkg::DROP_NO_LF;
               show     = 1'b1;
            end
            cur_phase = nsd_pkg::PH_IDLE;
         end
         default: cur_phase = nsd_pkg::PH_IDLE;
      endcase
      if (r.in_frame) show = 1'b1;
      if (show) begin
         r.length = frame_count;
         r.xsum   = run_xor;
      end
      return r;
   endfunction

   task automatic check_field(input string what, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      frame_beat_type want;
      if (reset) begin
         expected_beats.delete();
         outstanding = 0;
         cur_phase   = nsd_pkg::PH_IDLE;
         run_xor     = 8'd0;
         frame_count = 8'd0;
         hi_nib      = 4'd0;
         hi_bad      = 1'b0;
         len_limit   = nsd_pkg::MAX_LEN_RESET;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: result beat with no byte outstanding, expected none, actual %0h",
                        $time, rsp_mon.byte_out);
               mismatches++;
            end else begin
               want = expected_beats.pop_front();
               outstanding = expected_beats.size();
               check_field("byte_out", want.byte_out, rsp_mon.byte_out);
               check_field("byte_in_frame", 8'(want.in_frame), 8'(rsp_mon.byte_in_frame));
               check_field("frame_start", 8'(want.start), 8'(rsp_mon.frame_start));
               check_field("frame_good", 8'(want.good), 8'(rsp_mon.frame_good));
               check_field("drop_reason", 8'(want.reason), 8'(rsp_mon.drop_reason));
               check_field("frame_length", want.length, rsp_mon.frame_length);
               check_field("computed_checksum", want.xsum, rsp_mon.computed_checksum);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_beats.push_back(deframe_byte(req_mon.rx_byte));
            outstanding = expected_beats.size();
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == nsd_pkg::CSR_MAX_LEN_ADDR) begin
            len_limit = csr_pwdata[7:0];
         end
      end
   end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the NMEA sentence deframer: clock, reset, byte stimulus,
// limit register writes, receiver stalls and the verdict.
// Depends on nsd_pkg, nsd_if, nmea_sentence_deframer_top and nsd_deframe_checker.
`timescale 1ns / 1ps

module tb;

   localparam int PHASE_ITEMS = 290;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 3000;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [nsd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                    csr_pwdata;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;
   int                             fail_count;
   int                             pending_count;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_req = 0;
   int hold_ack = 0;
   int quiet_cycles = 0;

   nsd_req_if req_ch();
   nsd_rsp_if rsp_ch();

   nmea_sentence_deframer_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   nsd_deframe_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
      if (n < 4'd10) return 8'("0" + n);
      return 8'((upper ? "A" : "a") + n - 10);
   endfunction

   // A byte that breaks the frame where a CR or an LF belongs; often a dollar.
   function automatic logic [7:0] intruder(input logic [7:0] avoid);
      logic [7:0] b;
      b = ($urandom_range(0, 2) == 0) ? nsd_pkg::CH_START : 8'($urandom_range(0, 255));
      if (b == avoid) b = nsd_pkg::CH_START;
      return b;
   endfunction

   task automatic push_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // The first edge lets the checker record the last accepted byte.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [7:0] opening_bytes [25];
      int         send_by_phase [6];
      int         recv_by_phase [6];
      int         max_by_phase [6];
      logic [7:0] line_q[$];
      logic [7:0] xsum;
      logic [7:0] b;
      int         cur_max;
      int         kind;
      int         blen;
      int         idx;
      int         items_sent;

      // Noise in idle, a good frame with a zero body byte and lowercase digits,
      // a dollar where CR belongs, a stray byte where LF belongs, a bad digit.
      opening_bytes = '{8'h00, 8'hFF,
                        nsd_pkg::CH_START, 8'h00, "j", nsd_pkg::CH_STAR, "6", "a",
                        nsd_pkg::CH_CR, nsd_pkg::CH_LF,
                        nsd_pkg::CH_START, nsd_pkg::CH_STAR, "0", "0", nsd_pkg::CH_START,
                        nsd_pkg::CH_START, nsd_pkg::CH_STAR, "0", "0", nsd_pkg::CH_CR, "X",
                        nsd_pkg::CH_START, nsd_pkg::CH_STAR, "G", "0"};
      send_by_phase = '{0, 63, 0, 17, 0, 17};
      recv_by_phase = '{0, 0, 63, 17, 0, 17};
      max_by_phase  = '{8, 255, 0, 88, 120, 17};

      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= 8'd0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= nsd_pkg::CSR_MAX_LEN_ADDR;
      csr_pwdata     <= 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[k]) push_byte(opening_bytes[k]);
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         cur_max = (max_by_phase[ph] == 0) ? $urandom_range(9, 254) : max_by_phase[ph];
         send_idle_pct  <= send_by_phase[ph];
         recv_stall_pct <= recv_by_phase[ph];

         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= nsd_pkg::CSR_MAX_LEN_ADDR;
         csr_pwdata  <= 32'(cur_max);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;

         // The receiver holds off while the sender keeps offering, so the input backs up.
         if (ph == 4) hold_req <= hold_req + 1;

         items_sent = 0;
         while (items_sent < PHASE_ITEMS) begin
            line_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
               repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
            end else begin
               // Long bodies land on both sides of the length limit.
               if (kind >= 97) blen = $urandom_range(cur_max - 3, (cur_max > 9) ? cur_max - 9 : 0);
               else blen = $urandom_range(0, (cur_max < 16) ? cur_max - 6 : 10);
               line_q.push_back(nsd_pkg::CH_START);
               xsum = 8'd0;
               repeat (blen) begin
                  b = 8'($urandom_range(0, 255));
                  if (b == nsd_pkg::CH_STAR) b = b ^ 8'h01;
                  xsum = xsum ^ b;
                  line_q.push_back(b);
               end
               line_q.push_back(nsd_pkg::CH_STAR);
               if (kind >= 60 && kind < 68) xsum = xsum ^ 8'($urandom_range(1, 255));
               line_q.push_back(hex_char(xsum[7:4], 1'($urandom_range(0, 1))));
               line_q.push_back(hex_char(xsum[3:0], 1'($urandom_range(0, 1))));
               line_q.push_back(nsd_pkg::CH_CR);
               line_q.push_back(nsd_pkg::CH_LF);
               if (kind >= 68 && kind < 74) begin
                  idx = line_q.size() - 4 + $urandom_range(0, 1);
                  b = 8'($urandom_range(0, 255));
                  if ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") ||
                      (b >= "a" && b <= "f")) b = b ^ 8'h80;
                  line_q[idx] = b;
               end else if (kind >= 74 && kind < 80) begin
                  line_q[line_q.size() - 2] = intruder(nsd_pkg::CH_CR);
               end else if (kind >= 80 && kind < 86) begin
                  line_q[line_q.size() - 1] = intruder(nsd_pkg::CH_LF);
               end else if (kind >= 86 && kind < 92) begin
                  idx = $urandom_range(1, line_q.size() - 1);
                  line_q = line_q[0:idx-1];
               end
            end
            items_sent += line_q.size();
            foreach (line_q[k]) push_byte(line_q[k]);
         end
         settle();
      end

      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
